FILE: hdl/spi_gpio_expander_shadow_controller_core_assert.svh
// Assertion macros shared by the shadow controller modules.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef SPI_GPIO_EXPANDER_SHADOW_CONTROLLER_CORE_ASSERT_SVH
`define SPI_GPIO_EXPANDER_SHADOW_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SGESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SGESC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SGESC_ASSERT(lbl, prop, msg)
`define SGESC_NEVER(lbl, expr, msg)
`endif
`endif

FILE: hdl/sgesc_pkg.sv
package sgesc_pkg;

  // Geometry
  localparam int unsigned NUM_CHIPS_DEF  = 3;
  localparam int unsigned PINS_PER_CHIP  = 16;

  // Expander register map (port B is base + 1)
  localparam logic [4:0] REG_IODIR = 5'h00;
  localparam logic [4:0] REG_GPPU  = 5'h0C;
  localparam logic [4:0] REG_GPIO  = 5'h12;
  localparam logic [4:0] REG_OLAT  = 5'h14;

  // Reset values
  localparam logic [7:0] DIR_RST           = 8'hFF;
  localparam logic [2:0] MAX_TRIES_RST     = 3'd3;
  localparam logic [2:0] TRY_FIRST         = 3'd1;

  // Configuration register word index
  localparam logic CFG_IDX_MAX_TRIES = 1'b0;

  typedef enum logic [2:0] {
    KIND_SET_DIR    = 3'd0,
    KIND_SET_PULLUP = 3'd1,
    KIND_WRITE_PIN  = 3'd2,
    KIND_READ_PIN   = 3'd3,
    KIND_REFRESH    = 3'd4,
    KIND_FLUSH      = 3'd5,
    KIND_SPI_REPLY  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_STATUS = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_BUSY       = 3'd1,
    STS_RANGE      = 3'd2,
    STS_UNEXPECTED = 3'd3,
    STS_VERIFY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_FLUSH   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_EXEC   = 3'd1,
    ST_SEARCH = 3'd2,
    ST_WR     = 3'd3,
    ST_RD     = 3'd4
  } ctl_state_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LOAD   = 3'd1,
    CMD_EXEC   = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_WR     = 3'd4,
    CMD_RD     = 3'd5
  } dp_cmd_e;

  typedef enum logic [1:0] {
    NX_DONE   = 2'd0,
    NX_SEARCH = 2'd1,
    NX_PAIR   = 2'd2
  } dp_next_e;

  // Controller to datapath
  typedef struct packed {
    dp_cmd_e cmd;
  } dp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    dp_next_e next;
  } dp_sts_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] pin;
    logic       value;
    logic [7:0] reply_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] chip;
    logic [4:0] reg_addr;
    logic [7:0] data;
    logic       pin_value;
    logic [2:0] status;
    logic       last;
  } result_t;

  // Build a status-only result
  function automatic result_t status_result(status_e sts, logic last);
    result_t r;
    r           = '0;
    r.action    = ACT_STATUS;
    r.status    = sts;
    r.last      = last;
    return r;
  endfunction

  // Build an SPI register transaction
  function automatic result_t spi_result(action_e act, logic [1:0] chip,
                                         logic [4:0] addr, logic [7:0] data,
                                         logic last);
    result_t r;
    r           = '0;
    r.action    = act;
    r.chip      = chip;
    r.reg_addr  = addr;
    r.data      = data;
    r.status    = STS_OK;
    r.last      = last;
    return r;
  endfunction

endpackage

FILE: hdl/sgesc_ctrl.sv
`include "spi_gpio_expander_shadow_controller_core_assert.svh"

module sgesc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  sgesc_pkg::dp_sts_t sts_i,
  output sgesc_pkg::dp_ctl_t ctl_o
);

  sgesc_pkg::ctl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sgesc_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = sgesc_pkg::ST_EXEC;
        end
      end
      sgesc_pkg::ST_EXEC: begin
        case (sts_i.next)
          sgesc_pkg::NX_SEARCH: state_d = sgesc_pkg::ST_SEARCH;
          sgesc_pkg::NX_PAIR:   state_d = sgesc_pkg::ST_WR;
          default:              state_d = sgesc_pkg::ST_IDLE;
        endcase
      end
      sgesc_pkg::ST_SEARCH: begin
        if (sts_i.next == sgesc_pkg::NX_PAIR) begin
          state_d = sgesc_pkg::ST_WR;
        end else begin
          state_d = sgesc_pkg::ST_IDLE;
        end
      end
      sgesc_pkg::ST_WR: state_d = sgesc_pkg::ST_RD;
      sgesc_pkg::ST_RD: state_d = sgesc_pkg::ST_IDLE;
      default:          state_d = sgesc_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    ctl_o.cmd = sgesc_pkg::CMD_NONE;
    busy_o    = 1'b1;
    case (state_q)
      sgesc_pkg::ST_IDLE: begin
        busy_o    = 1'b0;
        ctl_o.cmd = start_i ? sgesc_pkg::CMD_LOAD : sgesc_pkg::CMD_NONE;
      end
      sgesc_pkg::ST_EXEC:   ctl_o.cmd = sgesc_pkg::CMD_EXEC;
      sgesc_pkg::ST_SEARCH: ctl_o.cmd = sgesc_pkg::CMD_SEARCH;
      sgesc_pkg::ST_WR:     ctl_o.cmd = sgesc_pkg::CMD_WR;
      sgesc_pkg::ST_RD:     ctl_o.cmd = sgesc_pkg::CMD_RD;
      default:              ctl_o.cmd = sgesc_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgesc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SGESC_ASSERT(a_accept_exec, (start_i && !busy_o) |=> (state_q == sgesc_pkg::ST_EXEC), "accepted item not executed")
  `SGESC_ASSERT(a_wr_then_rd, (state_q == sgesc_pkg::ST_WR) |=> (state_q == sgesc_pkg::ST_RD), "latch write not followed by read back")

endmodule

FILE: hdl/sgesc_dp.sv
`include "spi_gpio_expander_shadow_controller_core_assert.svh"

module sgesc_dp #(
  parameter int unsigned NUM_CHIPS = sgesc_pkg::NUM_CHIPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sgesc_pkg::dp_ctl_t  ctl_i,
  output sgesc_pkg::dp_sts_t  sts_o,
  input  sgesc_pkg::in_item_t item_i,
  input  logic [2:0]          max_tries_i,
  output sgesc_pkg::result_t  result_o,
  output logic                result_valid_o
);

  localparam int unsigned NUM_PORTS = 2 * NUM_CHIPS;
  localparam int unsigned PW        = $clog2(NUM_PORTS);
  localparam int unsigned SW        = $clog2(NUM_PORTS + 1);
  localparam logic [SW-1:0] NUM_PORTS_S = SW'(NUM_PORTS);
  localparam logic [7:0]    NUM_PINS_B  = 8'(NUM_CHIPS * sgesc_pkg::PINS_PER_CHIP);

  // Architectural state
  logic [7:0]          dir_q [NUM_PORTS];
  logic [7:0]          dir_d [NUM_PORTS];
  logic [7:0]          pu_q  [NUM_PORTS];
  logic [7:0]          pu_d  [NUM_PORTS];
  logic [7:0]          lat_q [NUM_PORTS];
  logic [7:0]          lat_d [NUM_PORTS];
  logic [7:0]          in_q  [NUM_PORTS];
  logic [7:0]          in_d  [NUM_PORTS];
  logic [NUM_PORTS-1:0] dirty_q, dirty_d;
  sgesc_pkg::mode_e    mode_q, mode_d;
  logic [SW-1:0]       seq_q, seq_d;
  logic [2:0]          try_q, try_d;
  logic                fail_q, fail_d;

  // Held item and result register
  sgesc_pkg::in_item_t item_q, item_d;
  sgesc_pkg::result_t  res_q, res_d;
  logic                res_vld_q, res_vld_d;

  // Decode helpers
  logic [PW-1:0] pin_port;
  logic [PW-1:0] seq_idx;
  logic [PW-1:0] lat_addr;
  logic [PW-1:0] found_idx;
  logic          found;
  logic          pin_ok;
  logic [7:0]    pin_mask;
  logic [7:0]    lat_rd, dir_rd, pu_rd, in_rd;
  logic [7:0]    dir_new, pu_new, lat_new;
  logic [SW-1:0] seq_inc;
  logic [2:0]    limit;
  sgesc_pkg::kind_e kind;

  assign kind     = sgesc_pkg::kind_e'(item_q.kind);
  assign pin_port = PW'({item_q.pin[5:4], item_q.pin[3]});
  assign seq_idx  = seq_q[PW-1:0];
  assign seq_inc  = seq_q + SW'(1);
  assign pin_ok   = ({2'b00, item_q.pin} < NUM_PINS_B);
  assign pin_mask = 8'b1 << item_q.pin[2:0];
  assign limit    = (max_tries_i == 3'd0) ? sgesc_pkg::TRY_FIRST : max_tries_i;

  // Latch shadow is read at the pin's port for a pin write, else at the sequencer port
  assign lat_addr = (kind == sgesc_pkg::KIND_WRITE_PIN) ? pin_port : seq_idx;
  assign lat_rd   = lat_q[lat_addr];
  assign dir_rd   = dir_q[pin_port];
  assign pu_rd    = pu_q[pin_port];
  assign in_rd    = in_q[pin_port];

  assign dir_new = item_q.value ? (dir_rd | pin_mask) : (dir_rd & ~pin_mask);
  assign pu_new  = item_q.value ? (pu_rd | pin_mask) : (pu_rd & ~pin_mask);
  assign lat_new = item_q.value ? (lat_rd | pin_mask) : (lat_rd & ~pin_mask);

  // Find the first dirty port at or above the sequencer port
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = NUM_PORTS - 1; i >= 0; i--) begin
      if (dirty_q[i] && (SW'(i) >= seq_q)) begin
        found     = 1'b1;
        found_idx = PW'(i);
      end
    end
  end

  // Step the shadows and the sequencer, and form the result
  always_comb begin
    dir_d      = dir_q;
    pu_d       = pu_q;
    lat_d      = lat_q;
    in_d       = in_q;
    dirty_d    = dirty_q;
    mode_d     = mode_q;
    seq_d      = seq_q;
    try_d      = try_q;
    fail_d     = fail_q;
    item_d     = item_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    sts_o.next = sgesc_pkg::NX_DONE;

    case (ctl_i.cmd)
      sgesc_pkg::CMD_LOAD: begin
        item_d = item_i;
      end

      sgesc_pkg::CMD_EXEC: begin
        case (kind)
          sgesc_pkg::KIND_SPI_REPLY: begin
            if (mode_q == sgesc_pkg::MODE_REFRESH && seq_q < NUM_PORTS_S) begin
              // Store the reply, then read the next input port or finish
              in_d[seq_idx] = item_q.reply_byte;
              res_vld_d     = 1'b1;
              if (seq_inc < NUM_PORTS_S) begin
                seq_d = seq_inc;
                res_d = sgesc_pkg::spi_result(sgesc_pkg::ACT_READ, 2'(seq_inc >> 1),
                                              sgesc_pkg::REG_GPIO | {4'b0, seq_inc[0]},
                                              8'h00, 1'b1);
              end else begin
                mode_d = sgesc_pkg::MODE_IDLE;
                seq_d  = '0;
                res_d  = sgesc_pkg::status_result(sgesc_pkg::STS_OK, 1'b1);
              end
            end else if (mode_q == sgesc_pkg::MODE_FLUSH && seq_q < NUM_PORTS_S) begin
              if (item_q.reply_byte == lat_rd) begin
                // Verified: drop the flag and move on
                dirty_d[seq_idx] = 1'b0;
                seq_d            = seq_inc;
                fail_d           = 1'b0;
                sts_o.next       = sgesc_pkg::NX_SEARCH;
              end else if (try_q < limit) begin
                try_d      = try_q + 3'd1;
                sts_o.next = sgesc_pkg::NX_PAIR;
              end else begin
                // Out of tries: drop the flag, report, continue with the rest
                dirty_d[seq_idx] = 1'b0;
                seq_d            = seq_inc;
                fail_d           = 1'b1;
                res_vld_d        = 1'b1;
                res_d            = sgesc_pkg::status_result(sgesc_pkg::STS_VERIFY, 1'b0);
                sts_o.next       = sgesc_pkg::NX_SEARCH;
              end
            end else begin
              res_vld_d = 1'b1;
              res_d     = sgesc_pkg::status_result(sgesc_pkg::STS_UNEXPECTED, 1'b1);
            end
          end

          sgesc_pkg::KIND_SET_DIR, sgesc_pkg::KIND_SET_PULLUP,
          sgesc_pkg::KIND_WRITE_PIN, sgesc_pkg::KIND_READ_PIN,
          sgesc_pkg::KIND_REFRESH, sgesc_pkg::KIND_FLUSH: begin
            if (mode_q != sgesc_pkg::MODE_IDLE) begin
              res_vld_d = 1'b1;
              res_d     = sgesc_pkg::status_result(sgesc_pkg::STS_BUSY, 1'b1);
            end else if (kind == sgesc_pkg::KIND_REFRESH) begin
              mode_d    = sgesc_pkg::MODE_REFRESH;
              seq_d     = '0;
              res_vld_d = 1'b1;
              res_d     = sgesc_pkg::spi_result(sgesc_pkg::ACT_READ, 2'b00,
                                                sgesc_pkg::REG_GPIO, 8'h00, 1'b1);
            end else if (kind == sgesc_pkg::KIND_FLUSH) begin
              seq_d      = '0;
              fail_d     = 1'b0;
              sts_o.next = sgesc_pkg::NX_SEARCH;
            end else if (!pin_ok) begin
              res_vld_d = 1'b1;
              res_d     = sgesc_pkg::status_result(sgesc_pkg::STS_RANGE, 1'b1);
            end else begin
              res_vld_d = 1'b1;
              case (kind)
                sgesc_pkg::KIND_SET_DIR: begin
                  dir_d[pin_port] = dir_new;
                  res_d = sgesc_pkg::spi_result(sgesc_pkg::ACT_WRITE, item_q.pin[5:4],
                                                sgesc_pkg::REG_IODIR | {4'b0, item_q.pin[3]},
                                                dir_new, 1'b1);
                end
                sgesc_pkg::KIND_SET_PULLUP: begin
                  pu_d[pin_port] = pu_new;
                  res_d = sgesc_pkg::spi_result(sgesc_pkg::ACT_WRITE, item_q.pin[5:4],
                                                sgesc_pkg::REG_GPPU | {4'b0, item_q.pin[3]},
                                                pu_new, 1'b1);
                end
                sgesc_pkg::KIND_WRITE_PIN: begin
                  lat_d[pin_port]   = lat_new;
                  dirty_d[pin_port] = 1'b1;
                  res_d = sgesc_pkg::status_result(sgesc_pkg::STS_OK, 1'b1);
                end
                default: begin
                  res_d           = sgesc_pkg::status_result(sgesc_pkg::STS_OK, 1'b1);
                  res_d.pin_value = |(in_rd & pin_mask);
                end
              endcase
            end
          end

          // Reserved kind: no result
          default: ;
        endcase
      end

      sgesc_pkg::CMD_SEARCH: begin
        if (found) begin
          mode_d     = sgesc_pkg::MODE_FLUSH;
          seq_d      = SW'(found_idx);
          try_d      = sgesc_pkg::TRY_FIRST;
          sts_o.next = sgesc_pkg::NX_PAIR;
        end else begin
          mode_d    = sgesc_pkg::MODE_IDLE;
          seq_d     = '0;
          try_d     = '0;
          res_vld_d = 1'b1;
          res_d     = sgesc_pkg::status_result(
                        fail_q ? sgesc_pkg::STS_VERIFY : sgesc_pkg::STS_OK, 1'b1);
        end
      end

      sgesc_pkg::CMD_WR: begin
        res_vld_d = 1'b1;
        res_d     = sgesc_pkg::spi_result(sgesc_pkg::ACT_WRITE, 2'(seq_q >> 1),
                                          sgesc_pkg::REG_OLAT | {4'b0, seq_q[0]},
                                          lat_rd, 1'b0);
      end

      sgesc_pkg::CMD_RD: begin
        res_vld_d = 1'b1;
        res_d     = sgesc_pkg::spi_result(sgesc_pkg::ACT_READ, 2'(seq_q >> 1),
                                          sgesc_pkg::REG_OLAT | {4'b0, seq_q[0]},
                                          8'h00, 1'b1);
      end

      default: ;
    endcase
  end

  // Control and shadow state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        dir_q[i] <= sgesc_pkg::DIR_RST;
        pu_q[i]  <= '0;
        lat_q[i] <= '0;
        in_q[i]  <= '0;
      end
      dirty_q   <= '0;
      mode_q    <= sgesc_pkg::MODE_IDLE;
      seq_q     <= '0;
      try_q     <= '0;
      fail_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      dir_q     <= dir_d;
      pu_q      <= pu_d;
      lat_q     <= lat_d;
      in_q      <= in_d;
      dirty_q   <= dirty_d;
      mode_q    <= mode_d;
      seq_q     <= seq_d;
      try_q     <= try_d;
      fail_q    <= fail_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

  `SGESC_ASSERT(a_status_clean, (result_valid_o && result_o.action == sgesc_pkg::ACT_STATUS) |-> (result_o.chip == 2'd0 && result_o.reg_addr == 5'd0 && result_o.data == 8'd0), "status result carries transaction fields")
  `SGESC_ASSERT(a_flush_port, (ctl_i.cmd == sgesc_pkg::CMD_NONE && mode_q == sgesc_pkg::MODE_FLUSH) |-> (seq_q < NUM_PORTS_S && try_q != 3'd0), "flush parked on invalid port or try count")

endmodule

FILE: hdl/spi_gpio_expander_shadow_controller_core.sv
// Channel   Ports                                   Transfer when
// -------   -------------------------------------   ---------------------------------
// command   start, busy, item_i                     start high and busy low at clk edge
// result    result_valid_o, result_o                result_valid_o high (one cycle)
// config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite, pready high
//           prdata, pready
//
// An accepted item is captured in the held-item register and stepped in the cycle after;
// a plain item keeps busy high only in the execute state and its result shows the cycle
// after. A flush step walks the controller through search, latch write and read back,
// and a new item is accepted only once the controller has returned to idle.
// Reset (rst_ni low, asynchronous) restores all shadows and max_tries at once.
// The receiver cannot stall: each result is shown for exactly one cycle.
module spi_gpio_expander_shadow_controller_core #(
  parameter int unsigned NUM_CHIPS = sgesc_pkg::NUM_CHIPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sgesc_pkg::in_item_t item_i,
  output sgesc_pkg::result_t  result_o,
  output logic                result_valid_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  sgesc_pkg::dp_ctl_t ctl;
  sgesc_pkg::dp_sts_t sts;
  logic [2:0]         max_tries_q, max_tries_d;
  logic               cfg_hit;

  // Configuration register, decoded on the word address
  assign cfg_hit = (paddr[2] == sgesc_pkg::CFG_IDX_MAX_TRIES) && (paddr[1:0] == 2'b00);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? 32'(max_tries_q) : 32'h0;

  always_comb begin
    max_tries_d = max_tries_q;
    if (psel && penable && pwrite && pready && paddr[2] == sgesc_pkg::CFG_IDX_MAX_TRIES) begin
      max_tries_d = pwdata[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tries_q <= sgesc_pkg::MAX_TRIES_RST;
    end else begin
      max_tries_q <= max_tries_d;
    end
  end

  sgesc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  sgesc_dp #(
    .NUM_CHIPS (NUM_CHIPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .item_i         (item_i),
    .max_tries_i    (max_tries_q),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
